// ===== rtl/core/lhc_pkg.sv =====
// Shared types and constants of the level histogram counters.
package lhc_pkg;

  // Fixed field widths of the command and result beats
  localparam int FUNC_W  = 3;
  localparam int LEVEL_W = 4;
  localparam int CFG_W   = 5;
  localparam int LCNT_W  = 32;
  localparam int SUM_O_W = 36;
  localparam int PROB_W  = 17;

  // Function codes; codes above refresh behave as a query
  localparam logic [FUNC_W-1:0] FUNC_INC     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEC     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REFRESH = 3'd4;

  // Fraction divider: one integer bit plus sixteen fraction bits, then a round step
  localparam int Q_STEPS = 17;
  localparam int STEP_W  = 5;
  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

  // Level count in use after reset
  localparam int LEVELS_RESET = 16;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_SUM_START,
    ST_SUM,
    ST_REF_CHECK,
    ST_DIV_LOAD,
    ST_DIV,
    ST_OUT_RD,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/lhc_if.sv =====
// Handshake channels: command beats, result beats and the config write channel.
interface lhc_cmd_if;
  import lhc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [LEVEL_W-1:0] level;
  modport source (output valid, func, level, input ready);
  modport sink   (input valid, func, level, output ready);
endinterface

interface lhc_res_if;
  import lhc_pkg::*;
  logic               valid;
  logic               ready;
  logic [LCNT_W-1:0]  level_count;
  logic [SUM_O_W-1:0] cumulative_count;
  logic [SUM_O_W-1:0] total_count;
  logic [PROB_W-1:0]  probability;
  logic               level_ok;
  modport source (output valid, level_count, cumulative_count, total_count, probability,
                  level_ok, input ready);
  modport sink   (input valid, level_count, cumulative_count, total_count, probability,
                  level_ok, output ready);
endinterface

interface lhc_cfg_if;
  import lhc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/lhc_alu.sv =====
// Shared add/subtract unit; carry out doubles as the a >= b flag on subtract.
module lhc_alu #(
  parameter int WIDTH = 37
) (
  input  lhc_pkg::alu_op_t   op,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [WIDTH-1:0]   sum,
  output logic               carry
);
  import lhc_pkg::*;

  logic             sub;
  logic [WIDTH-1:0] b_x;

  // Subtract as a plus inverted b plus one
  assign sub = (op == ALU_SUB);
  assign b_x = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_x} + (WIDTH + 1)'(sub);

endmodule

// ===== rtl/core/lhc_ctrl.sv =====
// Sequencer with counter and probability stores, sum walk and fraction divider.
module lhc_ctrl #(
  parameter int MAX_LEVELS  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_wr,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]                 n_new,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]                 n,
  lhc_cmd_if.sink                                         cmd,
  lhc_res_if.source                                       res,
  output lhc_pkg::alu_op_t                                alu_op,
  output logic [COUNT_WIDTH+$clog2(MAX_LEVELS):0]         alu_a,
  output logic [COUNT_WIDTH+$clog2(MAX_LEVELS):0]         alu_b,
  input  logic [COUNT_WIDTH+$clog2(MAX_LEVELS):0]         alu_sum,
  input  logic                                            alu_carry
);
  import lhc_pkg::*;

  localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int NW    = $clog2(MAX_LEVELS + 1);
  localparam int SUM_W = COUNT_WIDTH + $clog2(MAX_LEVELS);
  localparam int AW    = SUM_W + 1;

  state_t state, state_next;

  logic [FUNC_W-1:0]      func_r;
  logic [IDX_W-1:0]       level_r;
  logic                   ok_r;
  logic [IDX_W-1:0]       last_r;
  logic [IDX_W-1:0]       idx;
  logic [SUM_W-1:0]       total;
  logic [SUM_W-1:0]       cum;
  logic [AW-1:0]          rem;
  logic [PROB_W-1:0]      quo;
  logic [STEP_W-1:0]      step;

  logic [COUNT_WIDTH-1:0] cnt_mem [MAX_LEVELS];
  logic [PROB_W-1:0]      prob_mem [MAX_LEVELS];
  logic [MAX_LEVELS-1:0]  cnt_vld;
  logic [MAX_LEVELS-1:0]  prob_vld;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic                   cnt_rd_v;
  logic [PROB_W-1:0]      prob_rd;
  logic                   prob_rd_v;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [PROB_W-1:0]      prob_cur;

  logic [IDX_W-1:0]       rd_addr;
  logic                   cnt_we;
  logic                   prob_we;
  logic [PROB_W-1:0]      prob_wdata;
  logic [PROB_W-1:0]      q_rnd;
  logic [AW-1:0]          div_t;

  logic                   accept;
  logic                   ok_in;
  logic                   idx_last;
  logic                   div_done;
  logic                   out_load;

  logic                   out_vld;
  logic [LCNT_W-1:0]      out_lcnt;
  logic [SUM_O_W-1:0]     out_cum;
  logic [SUM_O_W-1:0]     out_total;
  logic [PROB_W-1:0]      out_prob;
  logic                   out_ok;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign ok_in     = (32'(cmd.level) < 32'(n));
  assign idx_last  = ((NW'(idx) + NW'(1)) == n);
  assign div_done  = (step == STEP_W'(Q_STEPS));
  assign cnt_cur   = cnt_rd_v ? cnt_rd : '0;
  assign prob_cur  = prob_rd_v ? prob_rd : '0;
  assign div_t     = (step == '0) ? rem : {rem[AW-2:0], 1'b0};
  assign q_rnd     = quo + PROB_W'(alu_carry);
  assign prob_wdata = (q_rnd > PROB_ONE) ? PROB_ONE : q_rnd;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, store controls and shared unit operands
  always_comb begin
    state_next = state;
    rd_addr    = level_r;
    cnt_we     = 1'b0;
    prob_we    = 1'b0;
    out_load   = 1'b0;
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    case (state)
      ST_IDLE: begin
        rd_addr = IDX_W'(cmd.level);
        if (accept) begin
          if ((cmd.func == FUNC_INC || cmd.func == FUNC_DEC) && ok_in) begin
            state_next = ST_UPD;
          end else begin
            state_next = ST_SUM_START;
          end
        end
      end
      ST_UPD: begin
        alu_a  = AW'(cnt_cur);
        alu_b  = AW'(1);
        alu_op = (func_r == FUNC_DEC) ? ALU_SUB : ALU_ADD;
        if (func_r == FUNC_DEC) begin
          cnt_we = (cnt_cur != '0);
        end else begin
          cnt_we = (cnt_cur != {COUNT_WIDTH{1'b1}});
        end
        state_next = ST_SUM_START;
      end
      ST_SUM_START: begin
        rd_addr    = '0;
        state_next = (n == '0) ? ST_REF_CHECK : ST_SUM;
      end
      ST_SUM: begin
        alu_a      = AW'(total);
        alu_b      = AW'(cnt_cur);
        rd_addr    = idx_last ? level_r : idx + IDX_W'(1);
        state_next = idx_last ? ST_REF_CHECK : ST_SUM;
      end
      ST_REF_CHECK: begin
        rd_addr = '0;
        if (func_r == FUNC_REFRESH && total != '0) begin
          state_next = ST_DIV_LOAD;
        end else begin
          state_next = ST_OUT_RD;
        end
      end
      ST_DIV_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = div_t;
        alu_b  = AW'(total);
        if (div_done) begin
          prob_we    = 1'b1;
          rd_addr    = idx_last ? level_r : idx + IDX_W'(1);
          state_next = idx_last ? ST_OUT_RD : ST_DIV_LOAD;
        end
      end
      ST_OUT_RD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld || res.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath registers of the item in flight
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          func_r  <= cmd.func;
          level_r <= IDX_W'(cmd.level);
          ok_r    <= ok_in;
          last_r  <= ok_in ? IDX_W'(cmd.level) : IDX_W'(n - NW'(1));
        end
      end
      ST_SUM_START: begin
        total <= '0;
        cum   <= '0;
        idx   <= '0;
      end
      ST_SUM: begin
        total <= SUM_W'(alu_sum);
        if (idx == last_r) begin
          cum <= SUM_W'(alu_sum);
        end
        if (!idx_last) begin
          idx <= idx + IDX_W'(1);
        end
      end
      ST_REF_CHECK: begin
        idx <= '0;
      end
      ST_DIV_LOAD: begin
        rem  <= AW'(cnt_cur);
        quo  <= '0;
        step <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          if (!idx_last) begin
            idx <= idx + IDX_W'(1);
          end
        end else begin
          rem  <= alu_carry ? alu_sum : div_t;
          quo  <= {quo[PROB_W-2:0], alu_carry};
          step <= step + STEP_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Valid bits: reset and config shrink drop entries, clear drops counter entries; writes mark them
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld  <= '0;
      prob_vld <= '0;
    end else begin
      if (cfg_wr) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          if (NW'(i) >= n_new) begin
            cnt_vld[i]  <= 1'b0;
            prob_vld[i] <= 1'b0;
          end
        end
      end
      if (accept && cmd.func == FUNC_CLEAR) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          if (NW'(i) < n) begin
            cnt_vld[i] <= 1'b0;
          end
        end
      end
      if (cnt_we) begin
        cnt_vld[level_r] <= 1'b1;
      end
      if (prob_we) begin
        prob_vld[idx] <= 1'b1;
      end
    end
  end

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[level_r] <= COUNT_WIDTH'(alu_sum);
    end
    if (prob_we) begin
      prob_mem[idx] <= prob_wdata;
    end
    cnt_rd    <= cnt_mem[rd_addr];
    cnt_rd_v  <= cnt_vld[rd_addr];
    prob_rd   <= prob_mem[rd_addr];
    prob_rd_v <= prob_vld[rd_addr];
  end

  // Result register: hold until the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lcnt  <= ok_r ? LCNT_W'(cnt_cur) : '0;
      out_cum   <= SUM_O_W'(cum);
      out_total <= SUM_O_W'(total);
      out_prob  <= ok_r ? prob_cur : '0;
      out_ok    <= ok_r;
    end
  end

  assign res.valid            = out_vld;
  assign res.level_count      = out_lcnt;
  assign res.cumulative_count = out_cum;
  assign res.total_count      = out_total;
  assign res.probability      = out_prob;
  assign res.level_ok         = out_ok;

endmodule

// ===== rtl/core/level_histogram_counters.sv =====
// Top level of the level histogram counters: config register and unit hookup.
//
// One command beat at a time: increment, decrement or query one level, or clear
// or refresh every level in use, of up to MAX_LEVELS event counters, each answered
// by one result beat with the level's count, the prefix sum up to the level, the
// total and the stored Q1.16 probability. Each command walks the counter store,
// which reads one counter per cycle through the shared adder; an increment or
// decrement of a level in use first updates its counter. A refresh adds, for each
// level, a counter read and a pass of the restoring divider that shares the same
// adder. A result beat still waiting in the output register holds the next one
// back. Reset takes effect at once, with no clearing pass. The config channel is
// always ready; write it only while no command is in flight.
module level_histogram_counters #(
  parameter int MAX_LEVELS  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  lhc_cfg_if.sink     cfg,
  lhc_cmd_if.sink     cmd,
  lhc_res_if.source   res
);
  import lhc_pkg::*;

  localparam int NW      = $clog2(MAX_LEVELS + 1);
  localparam int AW      = COUNT_WIDTH + $clog2(MAX_LEVELS) + 1;
  localparam int N_RESET = (LEVELS_RESET > MAX_LEVELS) ? MAX_LEVELS : LEVELS_RESET;

  logic [NW-1:0] n;
  logic [NW-1:0] n_next;
  logic          cfg_wr;

  alu_op_t       alu_op;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW-1:0] alu_sum;
  logic          alu_carry;

  // Saturate the written level count to the store depth
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign n_next    = (32'(cfg.data) > 32'(MAX_LEVELS)) ? NW'(MAX_LEVELS) : NW'(cfg.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= NW'(N_RESET);
    end else if (cfg_wr) begin
      n <= n_next;
    end
  end

  lhc_ctrl #(
    .MAX_LEVELS  (MAX_LEVELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .n_new     (n_next),
    .n         (n),
    .cmd       (cmd),
    .res       (res),
    .alu_op    (alu_op),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_sum   (alu_sum),
    .alu_carry (alu_carry)
  );

  lhc_alu #(
    .WIDTH (AW)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

endmodule

// ===== tb/level_histogram_counters_tb.sv =====
// Testbench of the level histogram counters: readout tracker class and top module.
import lhc_pkg::*;

typedef struct packed {
  logic [LCNT_W-1:0]  level_count;
  logic [SUM_O_W-1:0] cumulative_count;
  logic [SUM_O_W-1:0] total_count;
  logic [PROB_W-1:0]  probability;
  logic               level_ok;
} readout_t;

// Mirror of the counter and probability stores; queues the readout each command earns
class histogram_book #(int LEVELS = 16);
  bit [LCNT_W-1:0] counts [LEVELS];
  bit [PROB_W-1:0] shares [LEVELS];
  bit [CFG_W-1:0]  level_reg;
  readout_t        pending_readouts[$];
  int              mismatches;
  int              readouts_seen;

  function new();
    level_reg = CFG_W'(LEVELS_RESET);
    foreach (counts[i]) begin
      counts[i] = '0;
      shares[i] = '0;
    end
  endfunction

  // Clamp the register to the store depth
  function int unsigned levels_active();
    return (level_reg > LEVELS) ? LEVELS : int'(level_reg);
  endfunction

  // Zero every level that drops out of use
  function void write_levels(bit [CFG_W-1:0] value);
    level_reg = value;
    for (int i = levels_active(); i < LEVELS; i++) begin
      counts[i] = '0;
      shares[i] = '0;
    end
  endfunction

  // Q1.16 fraction of part over whole, rounded half up, capped at one
  function bit [PROB_W-1:0] q16_share(bit [LCNT_W-1:0] part, bit [SUM_O_W-1:0] whole);
    longint unsigned p, w, q;
    p = part;
    w = whole;
    q = ((p << 17) + w) / (w << 1);
    return (q > PROB_ONE) ? PROB_ONE : q[PROB_W-1:0];
  endfunction

  // Apply one accepted command and queue the readout it produces
  function void note_command(bit [FUNC_W-1:0] func, bit [LEVEL_W-1:0] level);
    int unsigned      n;
    int unsigned      last;
    bit               ok;
    bit [SUM_O_W-1:0] total;
    bit [SUM_O_W-1:0] prefix;
    readout_t         r;
    n  = levels_active();
    ok = level < n;
    case (func)
      FUNC_INC: if (ok && counts[level] != '1) counts[level]++;
      FUNC_DEC: if (ok && counts[level] != '0) counts[level]--;
      FUNC_CLEAR: for (int i = 0; i < n; i++) counts[i] = '0;
      default: ;
    endcase
    total = '0;
    for (int i = 0; i < n; i++) total += counts[i];
    // Keep the stored shares when there is nothing to divide by
    if (func == FUNC_REFRESH && total != 0) begin
      for (int i = 0; i < n; i++) shares[i] = q16_share(counts[i], total);
    end
    prefix = '0;
    if (n != 0) begin
      last = ok ? level : n - 1;
      for (int i = 0; i <= last; i++) prefix += counts[i];
    end
    r.level_count      = ok ? counts[level] : '0;
    r.cumulative_count = prefix;
    r.total_count      = total;
    r.probability      = ok ? shares[level] : '0;
    r.level_ok         = ok;
    pending_readouts.push_back(r);
  endfunction

  // Compare one result beat with the oldest queued readout
  function void check_readout(readout_t got);
    readout_t want;
    bit       bad;
    readouts_seen++;
    if (pending_readouts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: result beat with no command outstanding: count %0d total %0d",
                 got.level_count, got.total_count);
      return;
    end
    want = pending_readouts.pop_front();
    bad = (got.level_count !== want.level_count) ||
          (got.cumulative_count !== want.cumulative_count) ||
          (got.total_count !== want.total_count) ||
          (got.probability !== want.probability) ||
          (got.level_ok !== want.level_ok);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("tb: readout %0d mismatch", readouts_seen);
        $display("  exp: count %0d cum %0d total %0d prob %0d ok %0b", want.level_count,
                 want.cumulative_count, want.total_count, want.probability, want.level_ok);
        $display("  got: count %0d cum %0d total %0d prob %0d ok %0b", got.level_count,
                 got.cumulative_count, got.total_count, got.probability, got.level_ok);
      end
    end
  endfunction
endclass

module level_histogram_counters_tb;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_REFRESH + 1'b1;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;
  localparam int                SEGMENTS      = 10;

  logic clk;
  logic rst;

  lhc_cfg_if cfg_ch();
  lhc_cmd_if cmd_ch();
  lhc_res_if res_ch();

  histogram_book book = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int commands_sent;
  int refreshes_sent;
  int clears_sent;
  int level_writes;

  level_histogram_counters #(
    .MAX_LEVELS  (16),
    .COUNT_WIDTH (LCNT_W)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Result sink: check each beat, then pick ready for the next cycle
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        book.check_readout('{res_ch.level_count, res_ch.cumulative_count,
                             res_ch.total_count, res_ch.probability, res_ch.level_ok});
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Send one command beat after a random gap, note it on accept
  task automatic send_command(input logic [FUNC_W-1:0] func, input logic [LEVEL_W-1:0] level);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func  <= func;
    cmd_ch.level <= level;
    do @(posedge clk); while (!cmd_ch.ready);
    book.note_command(func, level);
    commands_sent++;
    if (func == FUNC_REFRESH) refreshes_sent++;
    if (func == FUNC_CLEAR) clears_sent++;
  endtask

  // Hold off commands until every queued readout has come back
  task automatic wait_for_readouts();
    cmd_ch.valid <= 1'b0;
    while (book.pending_readouts.size() != 0) @(posedge clk);
  endtask

  // Write the level count register
  task automatic set_levels(input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    book.write_levels(value);
    cfg_ch.valid <= 1'b0;
    level_writes++;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0]   seg_levels [SEGMENTS];
    int                 seg_items;
    int unsigned        n;
    int unsigned        pick;
    logic [FUNC_W-1:0]  func;
    logic [LEVEL_W-1:0] level;

    rst          <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.func  <= FUNC_QUERY;
    cmd_ch.level <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    tx_idle_pct  = 31;
    rx_idle_pct  = 82;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, refresh with zero total, decrement at zero
    send_command(FUNC_QUERY, 4'd0);
    send_command(FUNC_REFRESH, 4'd3);
    send_command(FUNC_DEC, 4'd0);
    // Fill the end levels, refresh to quarters and a half
    send_command(FUNC_INC, 4'd0);
    send_command(FUNC_INC, 4'd15);
    send_command(FUNC_INC, 4'd15);
    send_command(FUNC_INC, 4'd7);
    send_command(FUNC_REFRESH, 4'd15);
    send_command(FUNC_QUERY, 4'd7);
    // Spare codes act as queries
    send_command(FUNC_SPARE_LO, 4'd15);
    send_command(FUNC_SPARE_LO + 1'b1, 4'd0);
    send_command(FUNC_SPARE_HI, 4'd8);
    // Thirds: one share rounds up, one rounds down
    send_command(FUNC_DEC, 4'd15);
    send_command(FUNC_DEC, 4'd15);
    send_command(FUNC_INC, 4'd0);
    send_command(FUNC_REFRESH, 4'd7);
    // Clear keeps shares; a lone counter then refreshes to exactly one
    send_command(FUNC_CLEAR, 4'd9);
    send_command(FUNC_INC, 4'd3);
    send_command(FUNC_REFRESH, 4'd3);
    wait_for_readouts();

    // No levels in use: updates ignored, all sums zero
    set_levels('0);
    send_command(FUNC_INC, 4'd0);
    send_command(FUNC_QUERY, 4'd15);
    send_command(FUNC_REFRESH, 4'd0);
    wait_for_readouts();
    // Oversized count saturates; levels come back from zero
    set_levels('1);
    send_command(FUNC_QUERY, 4'd3);
    wait_for_readouts();

    // Random segments, each at its own level count and pacing
    seg_levels = '{5'd1, 5'd16, 5'd9, 5'd31, 5'd0, 5'd3, 5'd17, 5'd12, 5'd0, 5'd16};
    seg_levels[8] = CFG_W'($urandom_range(31));
    for (int s = 0; s < SEGMENTS; s++) begin
      if (s < 4) begin
        tx_idle_pct = 31;
        rx_idle_pct = 82;
      end else if (s < 7) begin
        tx_idle_pct = 82;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_levels(seg_levels[s]);
      n = book.levels_active();
      seg_items = (n == 0) ? 10 : 58;
      for (int k = 0; k < seg_items; k++) begin
        // Mostly increments so counts build up; rare clears and spare codes
        pick = $urandom_range(99);
        if (pick < 45) func = FUNC_INC;
        else if (pick < 65) func = FUNC_DEC;
        else if (pick < 80) func = FUNC_QUERY;
        else if (pick < 87) func = FUNC_REFRESH;
        else if (pick < 90) func = FUNC_CLEAR;
        else func = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
        if (n != 0 && $urandom_range(99) < 85) level = LEVEL_W'($urandom_range(n - 1));
        else level = LEVEL_W'($urandom());
        send_command(func, level);
      end
      wait_for_readouts();
    end

    // Let any stray beat show up before the verdict
    repeat (400) @(posedge clk);
    $display("tb: %0d commands sent (%0d refreshes, %0d clears), %0d readouts checked",
             commands_sent, refreshes_sent, clears_sent, book.readouts_seen);
    $display("tb: %0d level-count writes from 0 to 31 under three pacing phases",
             level_writes);
    if (book.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatched readouts", book.mismatches);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
